/* hdl/rpp_pkg.sv */
// Shared types, constants and helper functions of the point rotation unit.
// Used by rpp_trig and rotate_point_about_pivot_unit.
`default_nettype none

package rpp_pkg;

   localparam int TRIG_BITS   = 16;
   localparam int ANGLE_BITS  = 16;
   localparam int COORD_BITS  = 32;
   localparam int CW          = TRIG_BITS + 2;   // sin/cos width, signed
   localparam int WW          = COORD_BITS + 4;  // working coordinate width
   localparam int PW          = WW + CW;         // product width
   localparam int TRIG_SHIFT  = 30 - TRIG_BITS;
   localparam int NUM_REGS    = 6;
   localparam int ADDR_BITS   = 5;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(16384);
   localparam logic signed [CW-1:0] TRIG_ONE = CW'(1) <<< TRIG_BITS;

   localparam logic [2:0] REG_ROLL    = 3'd0;
   localparam logic [2:0] REG_PITCH   = 3'd1;
   localparam logic [2:0] REG_YAW     = 3'd2;
   localparam logic [2:0] REG_PIVOT_X = 3'd3;
   localparam logic [2:0] REG_PIVOT_Y = 3'd4;
   localparam logic [2:0] REG_PIVOT_Z = 3'd5;

   typedef logic [2:0][ANGLE_BITS-1:0] angles_type;

   typedef struct packed {
      logic signed [CW-1:0] roll_sin;
      logic signed [CW-1:0] roll_cos;
      logic signed [CW-1:0] pitch_sin;
      logic signed [CW-1:0] pitch_cos;
      logic signed [CW-1:0] yaw_sin;
      logic signed [CW-1:0] yaw_cos;
   } coef_type;

   typedef enum logic [2:0] {
      TRIG_IDLE,
      TRIG_ARG,
      TRIG_SQR,
      TRIG_MUL,
      TRIG_RCP,
      TRIG_DIV,
      TRIG_ACC,
      TRIG_FIN
   } trig_state_type;

   // Taylor divisor (2n)(2n+1)
   function automatic logic [8:0] taylor_div(input logic [3:0] n);
      case (n)
         4'd1:    taylor_div = 9'd6;
         4'd2:    taylor_div = 9'd20;
         4'd3:    taylor_div = 9'd42;
         4'd4:    taylor_div = 9'd72;
         4'd5:    taylor_div = 9'd110;
         4'd6:    taylor_div = 9'd156;
         4'd7:    taylor_div = 9'd210;
         4'd8:    taylor_div = 9'd272;
         default: taylor_div = 9'd1;
      endcase
   endfunction

   // floor(2^32 / taylor_div(n))
   function automatic logic [31:0] taylor_recip(input logic [3:0] n);
      case (n)
         4'd1:    taylor_recip = 32'd715827882;
         4'd2:    taylor_recip = 32'd214748364;
         4'd3:    taylor_recip = 32'd102261126;
         4'd4:    taylor_recip = 32'd59652323;
         4'd5:    taylor_recip = 32'd39045157;
         4'd6:    taylor_recip = 32'd27531841;
         4'd7:    taylor_recip = 32'd20452225;
         4'd8:    taylor_recip = 32'd15790320;
         default: taylor_recip = 32'd0;
      endcase
   endfunction

   // floor((v + half) / 2^TRIG_BITS)
   function automatic logic signed [WW-1:0] round_shift(input logic signed [PW:0] v);
      logic signed [PW:0] half;
      logic signed [PW:0] w;
      half = (PW+1)'(1) <<< (TRIG_BITS - 1);
      w = v + half;
      round_shift = WW'(w >>> TRIG_BITS);
   endfunction

   function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [WW:0] v);
      logic signed [WW:0] hi;
      logic signed [WW:0] lo;
      hi = (WW+1)'({1'b0, {(COORD_BITS-1){1'b1}}});
      lo = -((WW+1)'(1) <<< (COORD_BITS-1));
      if (v > hi) begin
         sat_coord = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else if (v < lo) begin
         sat_coord = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         sat_coord = v[COORD_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/rpp_trig.sv */
// Sine/cosine coefficient generator: Taylor series, constant divisors by reciprocal multiply.
// Depends on rpp_pkg.
`default_nettype none

module rpp_trig
   import rpp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [2:0] angle_write,
   input  wire angles_type angles,
   output coef_type        coef,
   output logic            busy
);

   trig_state_type state_ff, state_in;
   logic [2:0]  pending_ff, pending_in;
   logic [1:0]  sel_ff, sel_in;
   logic        phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] x2_ff, x2_in;
   logic [31:0] term_ff, term_in;
   logic signed [35:0] sum_ff, sum_in;
   logic [3:0]  n_ff, n_in;
   logic [31:0] div_ff, div_in;
   logic [31:0] quo_ff, quo_in;
   logic [9:0]  rem_ff, rem_in;
   coef_type    coef_ff;

   logic [ANGLE_BITS-1:0] v;
   logic [14:0] t;
   logic [47:0] arg_prod;
   logic [63:0] sq;
   logic [63:0] tp;
   logic [63:0] rp;
   logic [31:0] qd;
   logic [8:0]  dconst;
   logic [31:0] rconst;
   logic [31:0] quo_fix;
   logic [30:0] clamped;
   logic [31:0] rnd_sum;
   logic [TRIG_BITS:0] mag;
   logic signed [CW-1:0] fin_val;
   logic [2:0]  clear_mask;
   logic [1:0]  first_sel;

   always_comb begin
      first_sel = 2'd0;
      if (pending_ff[0]) begin
         first_sel = 2'd0;
      end else if (pending_ff[1]) begin
         first_sel = 2'd1;
      end else begin
         first_sel = 2'd2;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TRIG_IDLE: begin
            if (pending_ff != 3'd0) state_in = TRIG_ARG;
         end
         TRIG_ARG: state_in = TRIG_SQR;
         TRIG_SQR: state_in = TRIG_MUL;
         TRIG_MUL: state_in = TRIG_RCP;
         TRIG_RCP: state_in = TRIG_DIV;
         TRIG_DIV: state_in = TRIG_ACC;
         TRIG_ACC: state_in = (n_ff == 4'd8) ? TRIG_FIN : TRIG_MUL;
         TRIG_FIN: state_in = phase_ff ? TRIG_IDLE : TRIG_ARG;
         default:  state_in = TRIG_IDLE;
      endcase
   end

   always_comb begin
      v        = angles[sel_ff] + (phase_ff ? QUARTER : '0);
      t        = v[14] ? (15'd16384 - {1'b0, v[13:0]}) : {1'b0, v[13:0]};
      arg_prod = {17'd0, t} * {16'd0, PI_Q30} + 48'd16384;
      sq       = x_ff * x_ff + (64'd1 << 29);
      tp       = term_ff * x2_ff;
      dconst   = taylor_div(n_ff);
      rconst   = taylor_recip(n_ff);
      rp       = {32'd0, div_ff} * {32'd0, rconst};
      qd       = quo_ff * {23'd0, dconst};
      quo_fix  = quo_ff + {31'd0, (rem_ff >= {1'b0, dconst})};
      if (sum_ff < 0) begin
         clamped = '0;
      end else if (sum_ff > 36'sd1073741824) begin
         clamped = 31'd1073741824;
      end else begin
         clamped = sum_ff[30:0];
      end
      rnd_sum  = {1'b0, clamped} + (32'd1 << (TRIG_SHIFT - 1));
      mag      = rnd_sum[TRIG_SHIFT +: TRIG_BITS+1];
      fin_val  = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

      sel_in   = sel_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      clear_mask = 3'd0;
      case (state_ff)
         TRIG_IDLE: begin
            sel_in   = first_sel;
            phase_in = 1'b0;
         end
         TRIG_ARG: begin
            x_in   = arg_prod[46:15];
            neg_in = v[15];
         end
         TRIG_SQR: begin
            x2_in   = sq[61:30];
            term_in = x_ff;
            sum_in  = $signed({4'd0, x_ff});
            n_in    = 4'd1;
         end
         TRIG_MUL: begin
            div_in = tp[61:30];
         end
         TRIG_RCP: begin
            quo_in = rp[63:32];
         end
         TRIG_DIV: begin
            rem_in = 10'(div_ff - qd);
         end
         TRIG_ACC: begin
            term_in = quo_fix;
            sum_in  = n_ff[0] ? sum_ff - $signed({4'd0, quo_fix})
                              : sum_ff + $signed({4'd0, quo_fix});
            n_in    = n_ff + 4'd1;
         end
         TRIG_FIN: begin
            phase_in = 1'b1;
            if (phase_ff) clear_mask[sel_ff] = 1'b1;
         end
         default: begin
         end
      endcase
      pending_in = (pending_ff & ~clear_mask) | angle_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= TRIG_IDLE;
         pending_ff <= '0;
         coef_ff.roll_sin  <= '0;
         coef_ff.roll_cos  <= TRIG_ONE;
         coef_ff.pitch_sin <= '0;
         coef_ff.pitch_cos <= TRIG_ONE;
         coef_ff.yaw_sin   <= '0;
         coef_ff.yaw_cos   <= TRIG_ONE;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         if (state_ff == TRIG_FIN) begin
            case ({sel_ff, phase_ff})
               3'b000:  coef_ff.roll_sin  <= fin_val;
               3'b001:  coef_ff.roll_cos  <= fin_val;
               3'b010:  coef_ff.pitch_sin <= fin_val;
               3'b011:  coef_ff.pitch_cos <= fin_val;
               3'b100:  coef_ff.yaw_sin   <= fin_val;
               3'b101:  coef_ff.yaw_cos   <= fin_val;
               default: coef_ff.roll_sin  <= coef_ff.roll_sin;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff   <= sel_in;
      phase_ff <= phase_in;
      neg_ff   <= neg_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      term_ff  <= term_in;
      sum_ff   <= sum_in;
      n_ff     <= n_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign coef = coef_ff;
   assign busy = (state_ff != TRIG_IDLE) || (pending_ff != 3'd0);

endmodule

`default_nettype wire

/* hdl/rotate_point_about_pivot_unit.sv */
// One word per cycle sustained while rsp_tready is high and rpp_trig is not busy.
// The rate is set by the eight-stage rotate pipeline (subtract, three multiply/round pairs, add).
// A write to an angle register holds off input while rpp_trig recomputes sine and cosine
// (two passes of 8 Taylor terms).
// Reset clears the registers to zero; coefficients are valid immediately after reset.
// Depends on rpp_pkg and rpp_trig.
`default_nettype none

module rotate_point_about_pivot_unit
   import rpp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [95:0]          req_tdata,  // point_x, point_y, point_z
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [95:0]               rsp_tdata,  // rotated_x, rotated_y, rotated_z
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int STAGES = 8;

   logic [ANGLE_BITS-1:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [COORD_BITS-1:0] pivx_ff, pivy_ff, pivz_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic [2:0]  angle_write;
   angles_type  angles;
   coef_type    coef;
   logic        trig_busy;

   logic [STAGES-1:0] val_ff, val_in;
   logic [STAGES-1:0] en;

   logic signed [WW-1:0] s0x_ff, s0y_ff, s0z_ff;
   logic signed [PW-1:0] s1a_ff, s1b_ff, s1c_ff, s1d_ff;
   logic signed [WW-1:0] s1x_ff;
   logic signed [WW-1:0] s2x_ff, s2y_ff, s2z_ff;
   logic signed [PW-1:0] s3a_ff, s3b_ff, s3c_ff, s3d_ff;
   logic signed [WW-1:0] s3y_ff;
   logic signed [WW-1:0] s4x_ff, s4y_ff, s4z_ff;
   logic signed [PW-1:0] s5a_ff, s5b_ff, s5c_ff, s5d_ff;
   logic signed [WW-1:0] s5z_ff;
   logic signed [WW-1:0] s6x_ff, s6y_ff, s6z_ff;
   logic [95:0]          out_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      angle_write = 3'd0;
      if (csr_wr) begin
         case (csr_idx)
            REG_ROLL:  angle_write = 3'b001;
            REG_PITCH: angle_write = 3'b010;
            REG_YAW:   angle_write = 3'b100;
            default:   angle_write = 3'b000;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff  <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
         pivx_ff  <= '0;
         pivy_ff  <= '0;
         pivz_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ROLL:    roll_ff  <= csr_pwdata[ANGLE_BITS-1:0];
            REG_PITCH:   pitch_ff <= csr_pwdata[ANGLE_BITS-1:0];
            REG_YAW:     yaw_ff   <= csr_pwdata[ANGLE_BITS-1:0];
            REG_PIVOT_X: pivx_ff  <= $signed(csr_pwdata);
            REG_PIVOT_Y: pivy_ff  <= $signed(csr_pwdata);
            REG_PIVOT_Z: pivz_ff  <= $signed(csr_pwdata);
            default:     pivx_ff  <= pivx_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ROLL:    csr_prdata = {16'd0, roll_ff};
         REG_PITCH:   csr_prdata = {16'd0, pitch_ff};
         REG_YAW:     csr_prdata = {16'd0, yaw_ff};
         REG_PIVOT_X: csr_prdata = pivx_ff;
         REG_PIVOT_Y: csr_prdata = pivy_ff;
         REG_PIVOT_Z: csr_prdata = pivz_ff;
         default:     csr_prdata = '0;
      endcase
   end

   assign angles = {yaw_ff, pitch_ff, roll_ff};

   rpp_trig u_trig (
      .clock       (clock),
      .reset       (reset),
      .angle_write (angle_write),
      .angles      (angles),
      .coef        (coef),
      .busy        (trig_busy)
   );

   always_comb begin
      en[STAGES-1] = !val_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !val_ff[k] || en[k+1];
      end
      req_tready = en[0] && !trig_busy;
      val_in[0] = en[0] ? (req_tvalid && req_tready) : val_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         val_in[k] = en[k] ? val_ff[k-1] : val_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0x_ff <= WW'($signed(req_tdata[31:0])) - WW'(pivx_ff);
         s0y_ff <= WW'($signed(req_tdata[63:32])) - WW'(pivy_ff);
         s0z_ff <= WW'($signed(req_tdata[95:64])) - WW'(pivz_ff);
      end
      if (en[1]) begin
         s1a_ff <= s0y_ff * coef.roll_cos;
         s1b_ff <= s0z_ff * coef.roll_sin;
         s1c_ff <= s0z_ff * coef.roll_cos;
         s1d_ff <= s0y_ff * coef.roll_sin;
         s1x_ff <= s0x_ff;
      end
      if (en[2]) begin
         s2x_ff <= s1x_ff;
         s2y_ff <= round_shift((PW+1)'(s1a_ff) + (PW+1)'(s1b_ff));
         s2z_ff <= round_shift((PW+1)'(s1c_ff) - (PW+1)'(s1d_ff));
      end
      if (en[3]) begin
         s3a_ff <= s2x_ff * coef.pitch_cos;
         s3b_ff <= s2z_ff * coef.pitch_sin;
         s3c_ff <= s2z_ff * coef.pitch_cos;
         s3d_ff <= s2x_ff * coef.pitch_sin;
         s3y_ff <= s2y_ff;
      end
      if (en[4]) begin
         s4x_ff <= round_shift((PW+1)'(s3a_ff) + (PW+1)'(s3b_ff));
         s4y_ff <= s3y_ff;
         s4z_ff <= round_shift((PW+1)'(s3c_ff) - (PW+1)'(s3d_ff));
      end
      if (en[5]) begin
         s5a_ff <= s4x_ff * coef.yaw_cos;
         s5b_ff <= s4y_ff * coef.yaw_sin;
         s5c_ff <= s4y_ff * coef.yaw_cos;
         s5d_ff <= s4x_ff * coef.yaw_sin;
         s5z_ff <= s4z_ff;
      end
      if (en[6]) begin
         s6x_ff <= round_shift((PW+1)'(s5a_ff) + (PW+1)'(s5b_ff));
         s6y_ff <= round_shift((PW+1)'(s5c_ff) - (PW+1)'(s5d_ff));
         s6z_ff <= s5z_ff;
      end
      if (en[7]) begin
         out_ff[31:0]  <= sat_coord((WW+1)'(s6x_ff) + (WW+1)'(pivx_ff));
         out_ff[63:32] <= sat_coord((WW+1)'(s6y_ff) + (WW+1)'(pivy_ff));
         out_ff[95:64] <= sat_coord((WW+1)'(s6z_ff) + (WW+1)'(pivz_ff));
      end
   end

   assign rsp_tvalid = val_ff[STAGES-1];
   assign rsp_tdata  = out_ff;

   a_angle_holds_input: assert property (@(posedge clock) disable iff (reset)
      (angle_write != 3'd0) |=> !req_tready)
      else $error("input accepted right after an angle write");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      !trig_busy |-> (coef.roll_cos <= TRIG_ONE && coef.roll_cos >= -TRIG_ONE &&
                      coef.yaw_sin <= TRIG_ONE && coef.yaw_sin >= -TRIG_ONE))
      else $error("coefficient out of range");

   a_reset_coef: assert property (@(posedge clock)
      reset |=> (coef.pitch_cos == TRIG_ONE && coef.pitch_sin == '0))
      else $error("coefficients not at identity after reset");

endmodule

`default_nettype wire
